// ===== rtl/tfpp_pkg.sv =====
`timescale 1ns / 1ps
package tfpp_pkg;

	localparam int unsigned CLOCK_HZ_DEF = 16000000;

	localparam logic [2:0] OP_SET_FAN = 3'd0;
	localparam logic [2:0] OP_TONE    = 3'd1;
	localparam logic [2:0] OP_STOP    = 3'd2;
	localparam logic [2:0] OP_BOTTOM  = 3'd3;
	localparam logic [2:0] OP_MATCH   = 3'd4;

	localparam logic [2:0] PRESC_DIV1    = 3'b001;
	localparam logic [2:0] PRESC_DIV64   = 3'b011;
	localparam logic [2:0] PRESC_DIV1024 = 3'd5;

	localparam logic [15:0] IDLE_PERIOD = 16'd255;
	localparam logic [15:0] MAX16       = 16'hFFFF;
	localparam logic [7:0]  DUTY_FULL   = 8'd255;
	localparam logic [2:0]  SHIFT_RESET = 3'd3;
	localparam int unsigned DIV_STEPS   = 32;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic        tone;
		logic        beeper;
		logic        level;
		logic        pwm;
		logic [15:0] fan_cmp;
		logic [15:0] beep_cmp;
		logic [15:0] period;
		logic [2:0]  prescaler;
	} plan_t;

	typedef struct packed {
		logic  err;
		plan_t plan;
	} result_t;

endpackage

// ===== rtl/tone_and_fan_pwm_planner_core.sv =====
`timescale 1ns / 1ps
// Set-fan full/zero, timer events, ignored codes and errors are registered the next cycle.
// Partial set-fan duty and stop tone: one multiply, 32 divide steps, one finish.
// Start tone: two passes through the same 32-step restoring divider.
// Throughput: one command at a time; the next transfer is taken once the result register is free.
// Reset (arst_n low, asynchronous): prescaler 5, period/beep/fan compares 255, flags 0, shift 3.
module tone_and_fan_pwm_planner_core
	import tfpp_pkg::*;
#(
	parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // duty[7:0], frequency[23:8]
	input  logic [2:0]  s_tuser,  // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // prescaler_code[2:0], period_value[18:3], beep_compare[34:19],
	                              // fan_compare[50:35], fan_pwm_on[51], fan_level[52],
	                              // beeper_level[53], tone_on[54], error_flag[55]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata
);

	localparam logic [31:0] CLK_VAL = 32'(CLOCK_HZ);

	state_t      state_q, state_d;
	plan_t       plan_q, plan_d;
	result_t     res_q;
	logic        out_vld_q;
	logic [2:0]  shift_q;
	logic        load_d, err_d;

	logic [2:0]  op_q;
	logic        tone_phase_q;
	logic [15:0] ref_q, per_q, a_q, b_q;
	logic [2:0]  code_q;
	logic [31:0] dvd_q;
	logic [16:0] rem_q, div_q;
	logic [4:0]  cnt_q;

	logic        s_fire, out_free;
	logic [7:0]  duty;
	logic [15:0] freq, ref_in;
	logic [17:0] trial;
	logic        ge;
	logic [17:0] trial_sub;
	logic [15:0] q_sat;
	logic [31:0] c_adj, c_m1;
	logic [15:0] per_calc;
	logic [2:0]  code_calc;

	assign duty     = s_tdata[7:0];
	assign freq     = s_tdata[23:8];
	assign ref_in   = plan_q.tone ? plan_q.period : IDLE_PERIOD;
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = res_q;

	assign trial     = {rem_q, dvd_q[31]};
	assign ge        = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};
	assign q_sat     = (|dvd_q[31:16]) ? MAX16 : dvd_q[15:0];

	always_comb begin
		if (|dvd_q[31:16]) begin
			c_adj     = dvd_q >> 6;
			code_calc = PRESC_DIV64;
		end else begin
			c_adj     = dvd_q;
			code_calc = PRESC_DIV1;
		end
		c_m1 = c_adj - 32'd1;
		if (c_adj == 32'd0) begin
			per_calc = 16'd0;
		end else if (|c_m1[31:16]) begin
			per_calc = MAX16;
		end else begin
			per_calc = c_m1[15:0];
		end
	end

	always_comb begin
		state_d = state_q;
		plan_d  = plan_q;
		load_d  = 1'b0;
		err_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					load_d = 1'b1;
					case (s_tuser)
						OP_SET_FAN: begin
							if (duty == 8'd0 || duty == DUTY_FULL) begin
								plan_d.pwm     = 1'b0;
								plan_d.fan_cmp = 16'd0;
								plan_d.level   = (duty != 8'd0);
							end else begin
								load_d  = 1'b0;
								state_d = S_MUL;
							end
						end
						OP_TONE: begin
							if (freq == 16'd0 || ref_in == 16'd0) begin
								err_d = 1'b1;
							end else begin
								load_d  = 1'b0;
								state_d = S_DIV;
							end
						end
						OP_STOP: begin
							if (ref_in == 16'd0) begin
								err_d = 1'b1;
							end else begin
								load_d  = 1'b0;
								state_d = S_MUL;
							end
						end
						OP_BOTTOM: begin
							if (plan_q.tone) begin
								plan_d.beeper = 1'b1;
							end
						end
						OP_MATCH: begin
							if (plan_q.tone) begin
								plan_d.beeper = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (tone_phase_q) begin
					state_d = S_MUL;
				end else if (out_free) begin
					load_d         = 1'b1;
					state_d        = S_IDLE;
					plan_d.fan_cmp = q_sat;
					case (op_q)
						OP_SET_FAN: begin
							plan_d.pwm = 1'b1;
						end
						OP_TONE: begin
							plan_d.prescaler = code_q;
							plan_d.period    = per_q;
							plan_d.beep_cmp  = per_q >> shift_q;
							plan_d.tone      = 1'b1;
						end
						default: begin
							plan_d.prescaler = PRESC_DIV1024;
							plan_d.period    = IDLE_PERIOD;
							plan_d.beep_cmp  = IDLE_PERIOD;
							plan_d.tone      = 1'b0;
							plan_d.beeper    = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			out_vld_q        <= 1'b0;
			shift_q          <= SHIFT_RESET;
			plan_q.tone      <= 1'b0;
			plan_q.beeper    <= 1'b0;
			plan_q.level     <= 1'b0;
			plan_q.pwm       <= 1'b0;
			plan_q.fan_cmp   <= IDLE_PERIOD;
			plan_q.beep_cmp  <= IDLE_PERIOD;
			plan_q.period    <= IDLE_PERIOD;
			plan_q.prescaler <= PRESC_DIV1024;
		end else begin
			state_q <= state_d;
			plan_q  <= plan_d;
			if (cfg_we) begin
				shift_q <= cfg_wdata;
			end
			if (load_d) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_d) begin
			res_q <= {err_d, plan_d};
		end
		case (state_q)
			S_IDLE: begin
				op_q         <= s_tuser;
				ref_q        <= ref_in;
				tone_phase_q <= (s_tuser == OP_TONE);
				rem_q        <= '0;
				cnt_q        <= '0;
				dvd_q        <= CLK_VAL;
				if (s_tuser == OP_SET_FAN) begin
					a_q   <= {8'd0, duty};
					b_q   <= ref_in;
					div_q <= {9'd0, DUTY_FULL};
				end else if (s_tuser == OP_STOP) begin
					a_q   <= plan_q.fan_cmp;
					b_q   <= IDLE_PERIOD;
					div_q <= {1'b0, ref_in};
				end else begin
					a_q   <= plan_q.fan_cmp;
					b_q   <= IDLE_PERIOD;
					div_q <= {freq, 1'b0};
				end
			end
			S_MUL: begin
				dvd_q <= a_q * b_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				dvd_q <= {dvd_q[30:0], ge};
				rem_q <= ge ? trial_sub[16:0] : trial[16:0];
				cnt_q <= cnt_q + 5'd1;
			end
			S_FIN: begin
				if (tone_phase_q) begin
					tone_phase_q <= 1'b0;
					per_q        <= per_calc;
					code_q       <= code_calc;
					a_q          <= plan_q.fan_cmp;
					b_q          <= per_calc;
					div_q        <= {1'b0, ref_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("input ready outside idle");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == 5'(DIV_STEPS - 1)) |=> state_q == S_FIN)
		else $error("divider did not finish");
	a_mul_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_DIV)
		else $error("multiply not followed by divide");
	a_silent_timer: assert property (@(posedge clk) disable iff (!arst_n)
		!plan_q.tone |-> (plan_q.period == IDLE_PERIOD && plan_q.prescaler == PRESC_DIV1024))
		else $error("silent timer not at idle setup");
	a_silent_beeper: assert property (@(posedge clk) disable iff (!arst_n)
		!plan_q.tone |-> !plan_q.beeper)
		else $error("beeper driven while silent");
`endif

endmodule

// ===== tb/sv/tone_and_fan_pwm_planner_checker.sv =====
`timescale 1ns / 1ps
module tone_and_fan_pwm_planner_checker
	import tfpp_pkg::*;
#(
	parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	output int          fail_count,
	output int          pending
);

	logic [2:0]  shift_q;
	logic [2:0]  presc_q;
	logic [15:0] period_q;
	logic [15:0] beep_q;
	logic [15:0] fan_q;
	logic        pwm_q;
	logic        level_q;
	logic        beeper_q;
	logic        tone_q;

	result_t plan_q[$];

	function automatic logic [15:0] scale_clamp(longint unsigned val, longint unsigned mul,
			longint unsigned div);
		longint unsigned q;
		q = (val * mul) / div;
		return (q > 64'd65535) ? MAX16 : q[15:0];
	endfunction

	task automatic plan_command(input logic [2:0] op, input logic [7:0] duty,
			input logic [15:0] freq, output result_t res);
		longint unsigned base_period, c, per;
		logic [2:0] code;
		logic err;
		err = 1'b0;
		base_period = tone_q ? longint'(period_q) : longint'(IDLE_PERIOD);
		case (op)
			OP_SET_FAN: begin
				if (duty == 8'd0 || duty == DUTY_FULL) begin
					pwm_q = 1'b0;
					fan_q = 16'd0;
					level_q = (duty != 8'd0);
				end else begin
					pwm_q = 1'b1;
					fan_q = scale_clamp(duty, base_period, 255);
				end
			end
			OP_TONE: begin
				if (freq == 16'd0 || base_period == 0) begin
					err = 1'b1;
				end else begin
					c = longint'(CLOCK_HZ) / (2 * longint'(freq));
					code = PRESC_DIV1;
					if (c > 65535) begin
						c = c / 64;
						code = PRESC_DIV64;
					end
					if (c == 0)
						per = 0;
					else if (c - 1 > 65535)
						per = 65535;
					else
						per = c - 1;
					presc_q = code;
					fan_q = scale_clamp(fan_q, per, base_period);
					period_q = per[15:0];
					beep_q = period_q >> shift_q;
					tone_q = 1'b1;
				end
			end
			OP_STOP: begin
				if (base_period == 0) begin
					err = 1'b1;
				end else begin
					presc_q = PRESC_DIV1024;
					fan_q = scale_clamp(fan_q, IDLE_PERIOD, base_period);
					period_q = IDLE_PERIOD;
					beep_q = IDLE_PERIOD;
					tone_q = 1'b0;
					beeper_q = 1'b0;
				end
			end
			OP_BOTTOM: begin
				if (tone_q)
					beeper_q = 1'b1;
			end
			OP_MATCH: begin
				if (tone_q)
					beeper_q = 1'b0;
			end
			default: begin
			end
		endcase
		res.err = err;
		res.plan.prescaler = presc_q;
		res.plan.period = period_q;
		res.plan.beep_cmp = beep_q;
		res.plan.fan_cmp = fan_q;
		res.plan.pwm = pwm_q;
		res.plan.level = level_q;
		res.plan.beeper = beeper_q;
		res.plan.tone = tone_q;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t predicted, seen, want;
		if (!arst_n) begin
			shift_q = SHIFT_RESET;
			presc_q = PRESC_DIV1024;
			period_q = IDLE_PERIOD;
			beep_q = IDLE_PERIOD;
			fan_q = IDLE_PERIOD;
			pwm_q = 1'b0;
			level_q = 1'b0;
			beeper_q = 1'b0;
			tone_q = 1'b0;
			plan_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				shift_q = cfg_wdata;
			if (s_tvalid && s_tready) begin
				plan_command(s_tuser, s_tdata[7:0], s_tdata[23:8], predicted);
				plan_q.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				seen = result_t'(m_tdata);
				if (plan_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected transfer out: %h", m_tdata);
				end else begin
					want = plan_q.pop_front();
					if (seen.err !== want.err ||
							seen.plan.prescaler !== want.plan.prescaler ||
							seen.plan.period !== want.plan.period ||
							seen.plan.beep_cmp !== want.plan.beep_cmp ||
							seen.plan.fan_cmp !== want.plan.fan_cmp ||
							seen.plan.pwm !== want.plan.pwm ||
							seen.plan.level !== want.plan.level ||
							seen.plan.beeper !== want.plan.beeper ||
							seen.plan.tone !== want.plan.tone) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch exp: presc %0d per %0d beep %0d fan %0d pwm %b lvl %b bpr %b tone %b err %b",
								want.plan.prescaler, want.plan.period, want.plan.beep_cmp,
								want.plan.fan_cmp, want.plan.pwm, want.plan.level,
								want.plan.beeper, want.plan.tone, want.err);
							$display("         got: presc %0d per %0d beep %0d fan %0d pwm %b lvl %b bpr %b tone %b err %b",
								seen.plan.prescaler, seen.plan.period, seen.plan.beep_cmp,
								seen.plan.fan_cmp, seen.plan.pwm, seen.plan.level,
								seen.plan.beeper, seen.plan.tone, seen.err);
						end
					end
				end
			end
			pending <= plan_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import tfpp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [2:0]  s_tuser = OP_SET_FAN;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = SHIFT_RESET;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int counted = 0;

	int send_pct_tab[4] = '{0, 84, 0, 35};
	int stall_pct_tab[4] = '{0, 0, 84, 35};
	logic [2:0] shift_tab[8] = '{3'd1, 3'd7, 3'd2, 3'd6, 3'd4, 3'd7, 3'd1, 3'd5};

	tone_and_fan_pwm_planner_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tone_and_fan_pwm_planner_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [7:0] rand_duty();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'd0;
		if (r < 20)
			return DUTY_FULL;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] rand_freq();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 16'd0;
		if (r < 10)
			return 16'd122 + 16'($urandom_range(1));
		if (r < 30)
			return 16'($urandom_range(400, 1));
		return 16'($urandom_range(65535));
	endfunction

	task automatic send_cmd(input logic [2:0] op, input logic [7:0] duty,
			input logic [15:0] freq, input bit counts);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {freq, duty};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (counts)
			counted++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_shift(input logic [2:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_run(input int target);
		int stop_at, n, k;
		logic [2:0] op;
		stop_at = counted + target;
		while (counted < stop_at) begin
			if ($urandom_range(99) < 70) begin
				send_cmd(OP_TONE, rand_duty(), rand_freq(), 1'b1);
				n = $urandom_range(8, 1);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(9))
						0, 1, 2, 3: send_cmd(OP_BOTTOM, rand_duty(), rand_freq(), 1'b1);
						4, 5, 6: send_cmd(OP_MATCH, rand_duty(), rand_freq(), 1'b1);
						7, 8: send_cmd(OP_SET_FAN, rand_duty(), rand_freq(), 1'b1);
						default: send_cmd(OP_TONE, rand_duty(), rand_freq(), 1'b1);
					endcase
				end
				if ($urandom_range(9) != 0)
					send_cmd(OP_STOP, rand_duty(), rand_freq(), 1'b1);
			end else begin
				op = 3'($urandom_range(7));
				send_cmd(op, rand_duty(), rand_freq(), op <= OP_STOP);
			end
		end
	endtask

	initial begin
		int seg;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_BOTTOM, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_MATCH, 8'hFF, 16'hFFFF, 1'b1);
		send_cmd(3'd5, 8'hAA, 16'h5555, 1'b1);
		send_cmd(3'd6, 8'h55, 16'hAAAA, 1'b1);
		send_cmd(3'd7, 8'hFF, 16'hFFFF, 1'b1);
		send_cmd(OP_SET_FAN, DUTY_FULL, 16'd0, 1'b1);
		send_cmd(OP_SET_FAN, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_SET_FAN, 8'd1, 16'd0, 1'b1);
		send_cmd(OP_SET_FAN, 8'd254, 16'd0, 1'b1);
		send_cmd(OP_STOP, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_TONE, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_TONE, 8'd0, 16'd1, 1'b1);
		send_cmd(OP_BOTTOM, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_MATCH, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_BOTTOM, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_SET_FAN, 8'd200, 16'd0, 1'b1);
		send_cmd(OP_TONE, 8'd0, 16'd65535, 1'b1);
		send_cmd(OP_TONE, 8'd0, 16'd122, 1'b1);
		send_cmd(OP_TONE, 8'd0, 16'd123, 1'b1);
		send_cmd(OP_TONE, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_SET_FAN, 8'd128, 16'd0, 1'b1);
		send_cmd(OP_BOTTOM, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_STOP, 8'd0, 16'd0, 1'b1);
		send_cmd(OP_SET_FAN, DUTY_FULL, 16'd0, 1'b1);

		for (seg = 0; seg < 8; seg++) begin
			write_shift(shift_tab[seg]);
			send_idle_pct = send_pct_tab[seg % 4];
			recv_stall_pct = stall_pct_tab[seg % 4];
			random_run(110);
		end

		drain();
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== tone_and_fan_pwm_planner_core.f =====
rtl/tfpp_pkg.sv
rtl/tone_and_fan_pwm_planner_core.sv
tb/sv/tone_and_fan_pwm_planner_checker.sv
tb/sv/tb_top.sv
